>>> hdl/xamse_pkg.sv
package xamse_pkg;

   localparam logic [7:0] OP_ADD_R8_R8    = 8'h02;
   localparam logic [7:0] OP_ADD_R16_R16  = 8'h03;
   localparam logic [7:0] OP_ADD_AL_IMM8  = 8'h04;
   localparam logic [7:0] OP_ADD_AX_IMM16 = 8'h05;
   localparam logic [7:0] OP_GRP1_IMM16   = 8'h81;
   localparam logic [7:0] OP_MOV_R8_IMM   = 8'hB0;
   localparam logic [7:0] OP_MOV_R16_IMM  = 8'hB8;

   localparam logic [1:0] MODRM_MOD_REG   = 2'b11;
   localparam logic [2:0] GRP1_ADD_REG    = 3'b000;
   localparam logic [2:0] REG_CODE_NONE   = 3'd0;

   localparam logic [1:0] KIND_BAD     = 2'd0;
   localparam logic [1:0] KIND_ADD_REG = 2'd1;
   localparam logic [1:0] KIND_ADD_IMM = 2'd2;
   localparam logic [1:0] KIND_MOV     = 2'd3;

   typedef logic [2:0]  reg_code_type;
   typedef logic [15:0] word_type;

   typedef struct packed {
      logic [1:0]   kind;
      logic         byte_wide;
      reg_code_type dest;
      reg_code_type src;
      word_type     imm;
   } decode_type;

   typedef struct packed {
      logic         en;
      reg_code_type addr;
      word_type     data;
   } write_type;

   typedef struct packed {
      reg_code_type dest;
      logic         byte_wide;
      word_type     result;
      logic         carry;
      logic         zero;
      logic         unsupported;
   } result_type;

   // byte views al..bh map onto words ax..bx
   function automatic reg_code_type word_index(input reg_code_type code, input logic byte_wide);
      return byte_wide ? {1'b0, code[1:0]} : code;
   endfunction

endpackage

>>> hdl/x86_add_mov_subset_executor.sv
// Executes one register-form 8086 add or mov instruction per transaction and returns the
// destination, the value written, the carry and zero flags after it and an unsupported mark.
// Throughput is one transaction per clock unless rsp_tready stalls the output; a taken
// request passes through the registered read of the register file memory, the execute
// stage and the output register. The eight word registers sit in a synchronous
// memory with two read ports; a write landing on the same edge as a dependent read is
// bypassed, so back-to-back dependent instructions run without stalls. Registers read as
// zero after reset with no clearing pass, and unsupported encodings change no state.
module x86_add_mov_subset_executor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // opcode_byte, modrm_byte, immediate_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // dest_index, byte_wide, result_value, carry_flag,
                                    // zero_flag, unsupported, zero pad
);

   xamse_pkg::decode_type  dec;
   xamse_pkg::decode_type  s1_dec_ff;
   logic                   s1_valid_ff;
   logic                   req_take;
   logic                   exe_free;
   xamse_pkg::word_type    dest_word_raw;
   xamse_pkg::word_type    src_word_raw;
   xamse_pkg::write_type   wr;
   logic [1:0]             flags;
   xamse_pkg::result_type  rsp;

   xamse_decode u_decode (
      .opcode (req_tdata[7:0]),
      .modrm  (req_tdata[15:8]),
      .imm    (req_tdata[31:16]),
      .dec    (dec)
   );

   assign req_tready = !s1_valid_ff || exe_free;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_dec_ff <= dec;
      end
   end

   xamse_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_take),
      .rd_addr_a (xamse_pkg::word_index(dec.dest, dec.byte_wide)),
      .rd_addr_b (xamse_pkg::word_index(dec.src, dec.byte_wide)),
      .rd_data_a (dest_word_raw),
      .rd_data_b (src_word_raw),
      .wr        (wr)
   );

   xamse_execute u_execute (
      .clock         (clock),
      .reset         (reset),
      .s1_valid      (s1_valid_ff),
      .dec           (s1_dec_ff),
      .dest_word_raw (dest_word_raw),
      .src_word_raw  (src_word_raw),
      .rsp_ready     (rsp_tready),
      .out_free      (exe_free),
      .wr            (wr),
      .flags         (flags),
      .rsp_valid     (rsp_tvalid),
      .rsp           (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.unsupported, rsp.zero, rsp.carry, rsp.result,
                       rsp.byte_wide, rsp.dest};

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> s1_valid_ff && exe_free && s1_dec_ff.kind != xamse_pkg::KIND_BAD)
      else $error("register write without an advancing instruction");

   a_mov_keeps_flags: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && exe_free && s1_dec_ff.kind == xamse_pkg::KIND_MOV
      |=> flags == $past(flags))
      else $error("mov changed the flags");

   a_stall_blocks_request: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while execute stage is stalled");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && !wr.en)
      else $error("activity right after reset");

endmodule

>>> hdl/xamse_decode.sv
module xamse_decode (
   input  logic [7:0]             opcode,
   input  logic [7:0]             modrm,
   input  logic [15:0]            imm,
   output xamse_pkg::decode_type  dec
);

   always_comb begin
      dec.kind      = xamse_pkg::KIND_BAD;
      dec.byte_wide = 1'b0;
      dec.dest      = xamse_pkg::REG_CODE_NONE;
      dec.src       = xamse_pkg::REG_CODE_NONE;
      dec.imm       = imm;
      priority if (opcode == xamse_pkg::OP_ADD_R8_R8 && modrm[7:6] == xamse_pkg::MODRM_MOD_REG) begin
         dec.kind      = xamse_pkg::KIND_ADD_REG;
         dec.byte_wide = 1'b1;
         dec.dest      = modrm[5:3];
         dec.src       = modrm[2:0];
      end else if (opcode == xamse_pkg::OP_ADD_R16_R16
                   && modrm[7:6] == xamse_pkg::MODRM_MOD_REG) begin
         dec.kind = xamse_pkg::KIND_ADD_REG;
         dec.dest = modrm[5:3];
         dec.src  = modrm[2:0];
      end else if (opcode == xamse_pkg::OP_ADD_AL_IMM8) begin
         dec.kind      = xamse_pkg::KIND_ADD_IMM;
         dec.byte_wide = 1'b1;
      end else if (opcode == xamse_pkg::OP_ADD_AX_IMM16) begin
         dec.kind = xamse_pkg::KIND_ADD_IMM;
      end else if (opcode == xamse_pkg::OP_GRP1_IMM16
                   && modrm[7:6] == xamse_pkg::MODRM_MOD_REG
                   && modrm[5:3] == xamse_pkg::GRP1_ADD_REG
                   && modrm[2:0] != xamse_pkg::REG_CODE_NONE) begin
         dec.kind = xamse_pkg::KIND_ADD_IMM;
         dec.dest = modrm[2:0];
      end else if (opcode[7:3] == xamse_pkg::OP_MOV_R8_IMM[7:3]) begin
         dec.kind      = xamse_pkg::KIND_MOV;
         dec.byte_wide = 1'b1;
         dec.dest      = opcode[2:0];
      end else if (opcode[7:3] == xamse_pkg::OP_MOV_R16_IMM[7:3]) begin
         dec.kind = xamse_pkg::KIND_MOV;
         dec.dest = opcode[2:0];
      end else begin
         dec.kind = xamse_pkg::KIND_BAD;
      end
   end

endmodule

>>> hdl/xamse_regfile.sv
module xamse_regfile (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  xamse_pkg::reg_code_type  rd_addr_a,
   input  xamse_pkg::reg_code_type  rd_addr_b,
   output xamse_pkg::word_type      rd_data_a,
   output xamse_pkg::word_type      rd_data_b,
   input  xamse_pkg::write_type     wr
);

   xamse_pkg::word_type regs_ff [8];
   logic [7:0]          valid_ff;
   xamse_pkg::word_type data_a_ff;
   xamse_pkg::word_type data_b_ff;
   logic                valid_a_ff;
   logic                valid_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         data_a_ff  <= regs_ff[rd_addr_a];
         data_b_ff  <= regs_ff[rd_addr_b];
         valid_a_ff <= valid_ff[rd_addr_a];
         valid_b_ff <= valid_ff[rd_addr_b];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data_a = valid_a_ff ? data_a_ff : '0;
   assign rd_data_b = valid_b_ff ? data_b_ff : '0;

endmodule

>>> hdl/xamse_execute.sv
module xamse_execute (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    s1_valid,
   input  xamse_pkg::decode_type   dec,
   input  xamse_pkg::word_type     dest_word_raw,
   input  xamse_pkg::word_type     src_word_raw,
   input  logic                    rsp_ready,
   output logic                    out_free,
   output xamse_pkg::write_type    wr,
   output logic [1:0]              flags,
   output logic                    rsp_valid,
   output xamse_pkg::result_type   rsp
);

   xamse_pkg::write_type   fwd_ff;
   logic [1:0]             flags_ff;
   logic                   rsp_valid_ff;
   xamse_pkg::result_type  rsp_ff;
   xamse_pkg::result_type  rsp_in;

   xamse_pkg::reg_code_type dest_widx;
   xamse_pkg::reg_code_type src_widx;
   xamse_pkg::word_type     dest_word;
   xamse_pkg::word_type     src_word;
   logic [7:0]              a8;
   logic [7:0]              b8;
   xamse_pkg::word_type     b16;
   logic [8:0]              sum8;
   logic [16:0]             sum16;
   xamse_pkg::word_type     value;
   xamse_pkg::word_type     new_word;
   logic [7:0]              low8;
   logic                    wen;
   logic                    flag_upd;
   logic                    cf_new;
   logic                    zf_new;
   logic                    advance;

   assign dest_widx = xamse_pkg::word_index(dec.dest, dec.byte_wide);
   assign src_widx  = xamse_pkg::word_index(dec.src, dec.byte_wide);

   // bypass the write that landed on the same edge as the read
   assign dest_word = (fwd_ff.en && fwd_ff.addr == dest_widx) ? fwd_ff.data : dest_word_raw;
   assign src_word  = (fwd_ff.en && fwd_ff.addr == src_widx) ? fwd_ff.data : src_word_raw;

   assign a8    = dec.dest[2] ? dest_word[15:8] : dest_word[7:0];
   assign b8    = (dec.kind == xamse_pkg::KIND_ADD_REG)
                  ? (dec.src[2] ? src_word[15:8] : src_word[7:0]) : dec.imm[7:0];
   assign b16   = (dec.kind == xamse_pkg::KIND_ADD_REG) ? src_word : dec.imm;
   assign sum8  = {1'b0, a8} + {1'b0, b8};
   assign sum16 = {1'b0, dest_word} + {1'b0, b16};

   always_comb begin
      value    = '0;
      new_word = dest_word;
      low8     = '0;
      wen      = 1'b0;
      flag_upd = 1'b0;
      cf_new   = flags_ff[0];
      zf_new   = flags_ff[1];
      unique case (dec.kind)
         xamse_pkg::KIND_ADD_REG, xamse_pkg::KIND_ADD_IMM: begin
            wen      = 1'b1;
            flag_upd = 1'b1;
            if (dec.byte_wide) begin
               low8   = sum8[7:0];
               value  = {8'h00, low8};
               cf_new = sum8[8];
               zf_new = (low8 == 8'h00);
               new_word = dec.dest[2] ? {low8, dest_word[7:0]} : {dest_word[15:8], low8};
            end else begin
               value    = sum16[15:0];
               new_word = sum16[15:0];
               cf_new   = sum16[16];
               zf_new   = (sum16[15:0] == 16'h0000);
            end
         end
         xamse_pkg::KIND_MOV: begin
            wen = 1'b1;
            if (dec.byte_wide) begin
               low8     = dec.imm[7:0];
               value    = {8'h00, low8};
               new_word = dec.dest[2] ? {low8, dest_word[7:0]} : {dest_word[15:8], low8};
            end else begin
               value    = dec.imm;
               new_word = dec.imm;
            end
         end
         default: begin
            wen = 1'b0;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = s1_valid && out_free;

   assign wr.en   = advance && wen;
   assign wr.addr = dest_widx;
   assign wr.data = new_word;

   always_comb begin
      rsp_in.dest        = dec.dest;
      rsp_in.byte_wide   = dec.byte_wide;
      rsp_in.result      = value;
      rsp_in.carry       = cf_new;
      rsp_in.zero        = zf_new;
      rsp_in.unsupported = (dec.kind == xamse_pkg::KIND_BAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff.en    <= 1'b0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            fwd_ff <= wr;
         end
         if (advance && flag_upd) begin
            flags_ff <= {zf_new, cf_new};
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign flags     = flags_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
